/* src/qcss_pkg.sv */
// Shared constants for the quadrature count and smoothed speed core.
// Holds field widths, register indexes and smoothing constants.
// No dependencies.
package qcss_pkg;

  // Encoders that have pins in the input item
  localparam int PIN_CHANNELS = 3;
  // Encoders that appear in a result item
  localparam int OUT_CHANNELS = 3;
  // Width of every result field
  localparam int FIELD_W = 32;

  // Defaults of the top level parameters
  localparam int DEF_NUM_CHANNELS  = 3;
  localparam int DEF_COUNT_BITS    = 32;
  localparam int DEF_FRACTION_BITS = 8;

  // Smoothing weight in units of 1/256
  localparam int WEIGHT_W     = 9;
  localparam int WEIGHT_SHIFT = 8;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 9'd256;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd102;

  // Stream payload widths
  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 9 * FIELD_W;
  localparam int OUT_TUSER_W = 1;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = WEIGHT_W;
  localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING_WEIGHT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FALLING_EDGE_EN  = 2'd1;

endpackage

/* src/quadrature_count_and_smoothed_speed_core.sv */
// Quadrature counter for three encoders with smoothed speed per sampling tick.
// Each input item is registered in stage 1 and then in the result register before it can transfer out.
// Throughput: one item per cycle unless out_tready stalls; stage 1 counts edges and takes deltas, stage 2
// forms the smoothed speed (one 10x32 multiply pair per channel) and loads the result.
// Reset (rst_n low, synchronous) clears counts, deltas, speeds, edge history and
// both stage valids, and loads the register defaults.
module quadrature_count_and_smoothed_speed_core #(
  parameter int NUM_CHANNELS  = qcss_pkg::DEF_NUM_CHANNELS,
  parameter int COUNT_BITS    = qcss_pkg::DEF_COUNT_BITS,
  parameter int FRACTION_BITS = qcss_pkg::DEF_FRACTION_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [2:0] a_levels, [5:3] b_levels, [7:6] zero
  input  logic [qcss_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] sample_tick
  input  logic [qcss_pkg::IN_TUSER_W-1:0]     in_tuser,
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] position_0, [63:32] position_1, [95:64] position_2,
  // [127:96] step_delta_0, [159:128] step_delta_1, [191:160] step_delta_2,
  // [223:192] speed_0, [255:224] speed_1, [287:256] speed_2
  output logic [qcss_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] speed_updated
  output logic [qcss_pkg::OUT_TUSER_W-1:0]    out_tuser,
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qcss_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [qcss_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int FW      = qcss_pkg::FIELD_W;
  localparam int WW      = qcss_pkg::WEIGHT_W;
  localparam int PROD_W  = FW + WW + 1;
  localparam int ACC_W   = PROD_W + FRACTION_BITS + 1;
  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    ACC_W'(1 << (qcss_pkg::WEIGHT_SHIFT - 1));
  localparam logic signed [ACC_W-1:0] SPEED_MAX = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SPEED_MIN = -ACC_W'(64'sh8000_0000);

  // Configuration registers
  logic [WW-1:0] weight_r;
  logic          fall_en_r;

  // Stage 1: edge history, counts and deltas (also the stage 1 payload)
  logic [qcss_pkg::PIN_CHANNELS-1:0] prev_a_r;
  logic [COUNT_BITS-1:0]             count_r     [NUM_CHANNELS];
  logic [COUNT_BITS-1:0]             count_nxt   [NUM_CHANNELS];
  logic [COUNT_BITS-1:0]             tick_ref_r  [NUM_CHANNELS];
  logic [COUNT_BITS-1:0]             delta_r     [NUM_CHANNELS];
  logic                              s1_valid_r;
  logic                              s1_tick_r;

  // Stage 2: smoothed speed
  logic signed [FW-1:0]              speed_r     [NUM_CHANNELS];
  logic signed [FW-1:0]              speed_nxt   [NUM_CHANNELS];

  // Result register
  logic                              out_valid_r;
  logic                              out_upd_r;
  logic [FW-1:0]                     out_pos_r   [qcss_pkg::OUT_CHANNELS];
  logic [FW-1:0]                     out_delta_r [qcss_pkg::OUT_CHANNELS];
  logic [FW-1:0]                     out_speed_r [qcss_pkg::OUT_CHANNELS];
  logic [FW-1:0]                     pos_view    [qcss_pkg::OUT_CHANNELS];
  logic [FW-1:0]                     delta_view  [qcss_pkg::OUT_CHANNELS];
  logic [FW-1:0]                     speed_view  [qcss_pkg::OUT_CHANNELS];

  logic                              en2;
  logic                              en1;
  logic                              in_fire;
  logic                              tick_in;
  logic                              speed_load;
  logic [WW-1:0]                     w_eff;
  logic [WW-1:0]                     w_rest;

  // Handshake: stage 2 moves when the result slot is free or taken
  assign en2        = !out_valid_r || out_tready;
  assign en1        = !s1_valid_r || en2;
  assign in_tready  = en1;
  assign in_fire    = in_tvalid && in_tready;
  assign tick_in    = in_tuser[0];
  assign speed_load = en2 && s1_valid_r && s1_tick_r;
  assign cfg_ready  = 1'b1;

  // Clamp the weight to one and take its complement
  assign w_eff  = (weight_r > qcss_pkg::WEIGHT_ONE) ? qcss_pkg::WEIGHT_ONE : weight_r;
  assign w_rest = qcss_pkg::WEIGHT_ONE - w_eff;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r  <= qcss_pkg::WEIGHT_RESET;
      fall_en_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        qcss_pkg::REG_SMOOTHING_WEIGHT: weight_r  <= cfg_data;
        qcss_pkg::REG_FALLING_EDGE_EN:  fall_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage and result valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s1_tick_r   <= 1'b0;
      out_valid_r <= 1'b0;
      prev_a_r    <= '0;
    end else begin
      if (en1) begin
        s1_valid_r <= in_fire;
      end
      if (in_fire) begin
        s1_tick_r <= tick_in;
        prev_a_r  <= in_tdata[qcss_pkg::PIN_CHANNELS-1:0];
      end
      if (en2) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_ch
    logic                         was_a;
    logic                         now_a;
    logic                         b_hi;
    logic                         step_up;
    logic                         step_dn;
    logic signed [FW-1:0]         d_ext;
    logic signed [PROD_W-1:0]     prod_new;
    logic signed [PROD_W-1:0]     prod_old;
    logic signed [ACC_W-1:0]      acc;
    logic signed [ACC_W-1:0]      rnd;

    // Pins exist only for the first encoders
    if (c < qcss_pkg::PIN_CHANNELS) begin : g_pin
      assign was_a = prev_a_r[c];
      assign now_a = in_tdata[c];
      assign b_hi  = in_tdata[qcss_pkg::PIN_CHANNELS + c];
    end else begin : g_nopin
      assign was_a = 1'b0;
      assign now_a = 1'b0;
      assign b_hi  = 1'b0;
    end

    // Decode the A edge into a count direction
    always_comb begin
      step_up = 1'b0;
      step_dn = 1'b0;
      if (!was_a && now_a) begin
        step_up = b_hi;
        step_dn = !b_hi;
      end else if (was_a && !now_a && fall_en_r) begin
        step_up = !b_hi;
        step_dn = b_hi;
      end
      count_nxt[c] = count_r[c];
      if (step_up) begin
        count_nxt[c] = count_r[c] + 1'b1;
      end else if (step_dn) begin
        count_nxt[c] = count_r[c] - 1'b1;
      end
    end

    // Advance the count; on a tick take the delta and move the reference
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        count_r[c]    <= '0;
        tick_ref_r[c] <= '0;
        delta_r[c]    <= '0;
      end else if (in_fire) begin
        count_r[c] <= count_nxt[c];
        if (tick_in) begin
          delta_r[c]    <= count_nxt[c] - tick_ref_r[c];
          tick_ref_r[c] <= count_nxt[c];
        end
      end
    end

    // Blend delta and previous speed, round half up, saturate
    always_comb begin
      d_ext    = FW'($signed(delta_r[c]));
      prod_new = $signed({1'b0, w_eff}) * d_ext;
      prod_old = $signed({1'b0, w_rest}) * speed_r[c];
      acc      = (ACC_W'(prod_new) <<< FRACTION_BITS) + ACC_W'(prod_old);
      rnd      = (acc + ROUND_HALF) >>> qcss_pkg::WEIGHT_SHIFT;
      if (!s1_tick_r) begin
        speed_nxt[c] = speed_r[c];
      end else if (rnd > SPEED_MAX) begin
        speed_nxt[c] = SPEED_MAX[FW-1:0];
      end else if (rnd < SPEED_MIN) begin
        speed_nxt[c] = SPEED_MIN[FW-1:0];
      end else begin
        speed_nxt[c] = rnd[FW-1:0];
      end
    end

    // Hold the speed between ticks
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        speed_r[c] <= '0;
      end else if (speed_load) begin
        speed_r[c] <= speed_nxt[c];
      end
    end
  end

  // Map channels onto result fields; absent channels read as zero
  for (genvar o = 0; o < qcss_pkg::OUT_CHANNELS; o++) begin : g_out
    if (o < NUM_CHANNELS) begin : g_live
      assign pos_view[o]   = FW'($signed(count_r[o]));
      assign delta_view[o] = FW'($signed(delta_r[o]));
      assign speed_view[o] = speed_nxt[o];
    end else begin : g_zero
      assign pos_view[o]   = '0;
      assign delta_view[o] = '0;
      assign speed_view[o] = '0;
    end
  end

  // Load the result register as stage 2 advances
  always_ff @(posedge clk) begin
    if (en2 && s1_valid_r) begin
      out_upd_r <= s1_tick_r;
      for (int o = 0; o < qcss_pkg::OUT_CHANNELS; o++) begin
        out_pos_r[o]   <= pos_view[o];
        out_delta_r[o] <= delta_view[o];
        out_speed_r[o] <= speed_view[o];
      end
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tuser[0] = out_upd_r;
  assign out_tdata    = {out_speed_r[2], out_speed_r[1], out_speed_r[0],
                         out_delta_r[2], out_delta_r[1], out_delta_r[0],
                         out_pos_r[2],   out_pos_r[1],   out_pos_r[0]};

  // A stage 1 item reaches the result register with its tick flag
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    en2 && s1_valid_r |=> out_valid_r && (out_upd_r == $past(s1_tick_r)))
    else $error("stage 1 item did not reach the result register");

  // Channel 0 speed changes only when a tick item passes stage 2
  a_speed_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !speed_load |=> $stable(speed_r[0]))
    else $error("speed changed without a tick");

  // The channel 0 count moves by at most one step per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r[0] == $past(count_r[0])) ||
             (count_r[0] == $past(count_r[0]) + 1'b1) ||
             (count_r[0] == $past(count_r[0]) - 1'b1))
    else $error("count moved by more than one step");

  // Input stalls only when both stages are full and the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without a full pipeline");

endmodule
